// ----- rtl/ray_oriented_box_slab_test_top_assert.svh -----
// Assertion macros for the oriented box slab test block.
`ifndef RAY_ORIENTED_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_ORIENTED_BOX_SLAB_TEST_TOP_ASSERT_SVH
`ifndef SYNTH
`define ROBST_ASSERT_DELAY(lbl, a, n, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##(n) (c)) \
        else $error("robst: expected event missing after delay");
`define ROBST_ASSERT_PAST(lbl, c, a, n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (c) |-> $past((a), (n))) \
        else $error("robst: event without matching cause");
`else
`define ROBST_ASSERT_DELAY(lbl, a, n, c)
`define ROBST_ASSERT_PAST(lbl, c, a, n)
`endif
`endif

// ----- rtl/robst_pkg.sv -----
// Shared types and constants for the oriented box slab test block.
`timescale 1ns / 1ps
package robst_pkg;
    typedef longint unsigned u64_t;
    typedef longint s64_t;

    localparam int   TRIG_DEPTH_DEF = 256;
    localparam u64_t HALF_PI_Q30    = 64'd1686629713;
    localparam int   ONE_Q14        = 16384;

    localparam int AX_STAGES = 3;
    localparam int UN_W      = 33;
    localparam int UD_W      = 31;
    localparam int Q_W       = 33;
    localparam int NUM_W     = UN_W + 16;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_ANGLES = 2'd1;
    localparam logic [1:0] REG_HALF   = 2'd2;

    localparam logic [47:0] HALF_RESET = 48'd8421504;

    typedef logic signed [15:0] trig_t;

    typedef struct packed {
        trig_t sa;
        trig_t ca;
        trig_t sb;
        trig_t cb;
        trig_t sc;
        trig_t cc;
    } trig_set_t;

    typedef logic [2:0][2:0][15:0] axes_t;
endpackage

// ----- rtl/robst_trig.sv -----
// Sine and cosine of one 16-bit angle from a quarter-wave table.
`timescale 1ns / 1ps
module robst_trig
    import robst_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic [15:0] angle,
    output trig_t       sin_val,
    output trig_t       cos_val
);
    localparam int PW = $clog2(4 * TRIG_TABLE_DEPTH);
    localparam int RW = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam logic [PW-1:0] D1 = PW'(TRIG_TABLE_DEPTH);
    localparam logic [PW-1:0] D2 = PW'(2 * TRIG_TABLE_DEPTH);
    localparam logic [PW-1:0] D3 = PW'(3 * TRIG_TABLE_DEPTH);
    localparam logic [PW:0]   D4 = (PW + 1)'(4 * TRIG_TABLE_DEPTH);
    localparam logic [RW-1:0] DR = RW'(TRIG_TABLE_DEPTH);

    typedef logic [14:0] rom_t [0:TRIG_TABLE_DEPTH];

    function automatic u64_t cdiv(input u64_t a, input u64_t b);
        u64_t q;
        u64_t r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        u64_t x;
        u64_t term;
        u64_t v;
        s64_t sum;
        int   k;
        int   n;
        for (k = 0; k <= TRIG_TABLE_DEPTH; k++)
        begin
            x = cdiv(u64_t'(k) * HALF_PI_Q30 + u64_t'(TRIG_TABLE_DEPTH >> 1),
                     u64_t'(TRIG_TABLE_DEPTH));
            term = x;
            sum  = s64_t'(x);
            for (n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = cdiv(term, u64_t'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    sum = sum - s64_t'(term);
                else
                    sum = sum + s64_t'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (u64_t'(sum) + 64'd32768) >> 16;
            if (v > u64_t'(ONE_Q14))
                v = u64_t'(ONE_Q14);
            t[k] = 15'(v);
        end
        return t;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    function automatic trig_t sin_of(input logic [PW-1:0] ph);
        logic [PW-1:0] r;
        logic          q_odd;
        logic          q_neg;
        logic [RW-1:0] idx;
        logic [14:0]   mag;
        if (ph >= D3)
        begin
            q_odd = 1'b1; q_neg = 1'b1; r = ph - D3;
        end
        else if (ph >= D2)
        begin
            q_odd = 1'b0; q_neg = 1'b1; r = ph - D2;
        end
        else if (ph >= D1)
        begin
            q_odd = 1'b1; q_neg = 1'b0; r = ph - D1;
        end
        else
        begin
            q_odd = 1'b0; q_neg = 1'b0; r = ph;
        end
        idx = q_odd ? (DR - RW'(r)) : RW'(r);
        mag = SIN_ROM[idx];
        return q_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic [16+PW-1:0] prod;
    logic [PW-1:0]    ph_s;
    logic [PW:0]      ph_c_ext;
    logic [PW-1:0]    ph_c;

    assign prod     = {{PW{1'b0}}, angle} * (16 + PW)'(4 * TRIG_TABLE_DEPTH);
    assign ph_s     = prod[16+PW-1:16];
    assign ph_c_ext = {1'b0, ph_s} + (PW + 1)'(TRIG_TABLE_DEPTH);
    assign ph_c     = (ph_c_ext >= D4) ? PW'(ph_c_ext - D4) : PW'(ph_c_ext);
    assign sin_val  = sin_of(ph_s);
    assign cos_val  = sin_of(ph_c);
endmodule

// ----- rtl/robst_axes.sv -----
// Box axis matrix from sines and cosines, three register stages.
`timescale 1ns / 1ps
module robst_axes
    import robst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  trig_set_t trig,
    output logic      out_valid,
    output axes_t     axes
);
    logic signed [29:0] cbcc_reg, sasb_reg, casc_reg, casb_reg, sasc_reg;
    logic signed [29:0] cbsc_reg, sacc_reg, cacc_reg, sacb_reg, cacb_reg;
    trig_t              sb_a_reg, cc_a_reg, sc_a_reg;

    logic signed [44:0] m_sasbcc_reg, m_casbcc_reg, m_sasbsc_reg, m_casbsc_reg;
    logic signed [29:0] cbcc_b_reg, casc_b_reg, sasc_b_reg, cbsc_b_reg;
    logic signed [29:0] cacc_b_reg, sacc_b_reg, sacb_b_reg, cacb_b_reg;
    trig_t              sb_b_reg;

    axes_t axes_next;
    axes_t axes_reg;
    logic  v_a_reg, v_b_reg, v_c_reg;

    function automatic logic signed [29:0] mul2(input trig_t a, input trig_t b);
        return 30'(30'(a) * 30'(b));
    endfunction

    function automatic logic signed [44:0] sh14(input logic signed [29:0] p);
        return 45'(p) <<< 14;
    endfunction

    function automatic logic [15:0] rnd(input logic signed [44:0] v);
        logic signed [44:0] t;
        t = v + 45'sd134217728;
        return 16'(t >>> 28);
    endfunction

    always_ff @(posedge clk)
    begin
        cbcc_reg <= mul2(trig.cb, trig.cc);
        sasb_reg <= mul2(trig.sa, trig.sb);
        casc_reg <= mul2(trig.ca, trig.sc);
        casb_reg <= mul2(trig.ca, trig.sb);
        sasc_reg <= mul2(trig.sa, trig.sc);
        cbsc_reg <= mul2(trig.cb, trig.sc);
        sacc_reg <= mul2(trig.sa, trig.cc);
        cacc_reg <= mul2(trig.ca, trig.cc);
        sacb_reg <= mul2(trig.sa, trig.cb);
        cacb_reg <= mul2(trig.ca, trig.cb);
        sb_a_reg <= trig.sb;
        cc_a_reg <= trig.cc;
        sc_a_reg <= trig.sc;

        m_sasbcc_reg <= 45'(sasb_reg) * 45'(cc_a_reg);
        m_casbcc_reg <= 45'(casb_reg) * 45'(cc_a_reg);
        m_sasbsc_reg <= 45'(sasb_reg) * 45'(sc_a_reg);
        m_casbsc_reg <= 45'(casb_reg) * 45'(sc_a_reg);
        cbcc_b_reg   <= cbcc_reg;
        casc_b_reg   <= casc_reg;
        sasc_b_reg   <= sasc_reg;
        cbsc_b_reg   <= cbsc_reg;
        cacc_b_reg   <= cacc_reg;
        sacc_b_reg   <= sacc_reg;
        sacb_b_reg   <= sacb_reg;
        cacb_b_reg   <= cacb_reg;
        sb_b_reg     <= sb_a_reg;

        axes_reg <= axes_next;
    end

    always_comb
    begin
        axes_next       = '0;
        axes_next[0][0] = rnd(sh14(cbcc_b_reg));
        axes_next[0][1] = rnd(m_sasbcc_reg + sh14(casc_b_reg));
        axes_next[0][2] = rnd(sh14(sasc_b_reg) - m_casbcc_reg);
        axes_next[1][0] = rnd(-sh14(cbsc_b_reg));
        axes_next[1][1] = rnd(sh14(cacc_b_reg) - m_sasbsc_reg);
        axes_next[1][2] = rnd(m_casbsc_reg + sh14(sacc_b_reg));
        axes_next[2][0] = rnd(45'(sb_b_reg) <<< 28);
        axes_next[2][1] = rnd(-sh14(sacb_b_reg));
        axes_next[2][2] = rnd(sh14(cacb_b_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else
        begin
            v_a_reg <= in_valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
        end
    end

    assign out_valid = v_c_reg;
    assign axes      = axes_reg;
endmodule

// ----- rtl/robst_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module robst_div
    import robst_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [UN_W-1:0] un,
    input  logic [UD_W-1:0] ud,
    output logic            out_valid,
    output logic [Q_W-1:0]  quot,
    output logic            ovf
);
    localparam int CW = UD_W + Q_W;

    logic [NUM_W-1:0] rem_reg  [0:Q_W-1];
    logic [NUM_W-1:0] rem_next [0:Q_W-1];
    logic [Q_W-1:0]   quot_reg  [0:Q_W-1];
    logic [Q_W-1:0]   quot_next [0:Q_W-1];
    logic [UD_W-1:0]  ud_reg  [0:Q_W-1];
    logic [UD_W-1:0]  ud_next [0:Q_W-1];
    logic [Q_W-1:0]   ovf_reg;
    logic [Q_W-1:0]   ovf_next;
    logic [Q_W-1:0]   vld_reg;

    always_comb
    begin
        logic [NUM_W-1:0] r_in;
        logic [Q_W-1:0]   q_in;
        logic [UD_W-1:0]  d_in;
        logic [CW-1:0]    dsh;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                r_in        = {un, 16'b0};
                q_in        = '0;
                d_in        = ud;
                ovf_next[k] = CW'(un) >= (CW'(ud) << (Q_W - 16));
            end
            else
            begin
                r_in        = rem_reg[k-1];
                q_in        = quot_reg[k-1];
                d_in        = ud_reg[k-1];
                ovf_next[k] = ovf_reg[k-1];
            end
            dsh = CW'(d_in) << (Q_W - 1 - k);
            if (CW'(r_in) >= dsh)
            begin
                rem_next[k]  = NUM_W'(CW'(r_in) - dsh);
                quot_next[k] = q_in | (Q_W'(1) << (Q_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = r_in;
                quot_next[k] = q_in;
            end
            ud_next[k] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quot_reg[k] <= quot_next[k];
            ud_reg[k]   <= ud_next[k];
        end
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Q_W-2:0], in_valid};
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quot      = quot_reg[Q_W-1];
    assign ovf       = ovf_reg[Q_W-1];
endmodule

// ----- rtl/ray_oriented_box_slab_test_top.sv -----
// Throughput: one ray per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 33-stage slab-time dividers behind the axis and dot stages.
// Reset: rst_n clears all valid bits and loads the box registers with their defaults.
// Results carry no back-pressure: each item shows on done for one cycle.
`timescale 1ns / 1ps
`include "ray_oriented_box_slab_test_top_assert.svh"
module ray_oriented_box_slab_test_top
    import robst_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic signed [15:0] origin_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    output logic               done,
    output logic               hit,
    output logic signed [31:0] entry_time,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    localparam int LATENCY = 1 + AX_STAGES + 3 + Q_W + 4;

    typedef struct packed {
        logic [2:0][16:0] off;
        logic [2:0][15:0] dir;
    } ray_t;

    typedef struct packed {
        logic [2:0]      skip;
        logic [2:0][1:0] neg;
    } side_t;

    logic [47:0] center_reg, angles_reg, half_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            angles_reg <= '0;
            half_reg   <= HALF_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_CENTER: center_reg <= pwdata[47:0];
                REG_ANGLES: angles_reg <= pwdata[47:0];
                REG_HALF:   half_reg   <= pwdata[47:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_CENTER: prdata = {16'b0, center_reg};
            REG_ANGLES: prdata = {16'b0, angles_reg};
            REG_HALF:   prdata = {16'b0, half_reg};
            default:    prdata = '0;
        endcase
    end

    // Stage 1: trig lookup, offsets
    trig_set_t trig_next, trig_reg;
    ray_t      ray_next;
    ray_t      ray_d_reg [0:AX_STAGES];
    logic      v1_reg;
    logic      accept;
    logic signed [15:0] org [0:2];
    logic signed [15:0] dir [0:2];

    assign accept = start & ~busy;
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    robst_trig #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_x (
        .angle(angles_reg[15:0]), .sin_val(trig_next.sa), .cos_val(trig_next.ca));
    robst_trig #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_y (
        .angle(angles_reg[31:16]), .sin_val(trig_next.sb), .cos_val(trig_next.cb));
    robst_trig #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_z (
        .angle(angles_reg[47:32]), .sin_val(trig_next.sc), .cos_val(trig_next.cc));

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ray_next.off[j] = 17'($signed(center_reg[16*j +: 16])) - 17'(org[j]);
            ray_next.dir[j] = dir[j];
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg     <= trig_next;
        ray_d_reg[0] <= ray_next;
        for (int s = 1; s <= AX_STAGES; s++)
            ray_d_reg[s] <= ray_d_reg[s-1];
    end

    // Stages 2-4: axis matrix
    logic  ax_vld;
    axes_t axes;

    robst_axes u_axes (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .trig     (trig_reg),
        .out_valid(ax_vld),
        .axes     (axes)
    );

    // Stage 5: dot-product terms
    logic signed [30:0] cp_reg [0:2][0:2];
    logic signed [31:0] dp_reg [0:2][0:2];
    ray_t               ray4;
    assign ray4 = ray_d_reg[AX_STAGES];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                cp_reg[i][j] <= 31'(32'($signed(ray4.dir[j])) * 32'($signed(axes[i][j])));
                dp_reg[i][j] <= 32'(32'($signed(ray4.off[j])) * 32'($signed(axes[i][j])));
            end
    end

    // Stage 6: sums
    logic signed [31:0] cos_reg  [0:2];
    logic signed [32:0] dist_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cos_reg[i]  <= 32'(cp_reg[i][0]) + 32'(cp_reg[i][1]) + 32'(cp_reg[i][2]);
            dist_reg[i] <= 33'(dp_reg[i][0]) + 33'(dp_reg[i][1]) + 33'(dp_reg[i][2]);
        end
    end

    // Stage 7: slab numerators and magnitudes
    logic [2:0][1:0][UN_W-1:0] un_reg;
    logic [2:0][UD_W-1:0]      ud_reg;
    side_t                     side_next, side7_reg;
    logic [2:0][1:0][UN_W-1:0] un_next;
    logic [2:0][UD_W-1:0]      ud_next;
    logic                      v7_reg;

    always_comb
    begin
        logic signed [33:0] h;
        logic signed [33:0] n1;
        logic signed [33:0] n2;
        for (int i = 0; i < 3; i++)
        begin
            h  = $signed({4'b0, half_reg[16*i +: 16], 14'b0});
            n1 = 34'(dist_reg[i]) - h;
            n2 = 34'(dist_reg[i]) + h;
            un_next[i][0] = n1[33] ? UN_W'(-n1) : UN_W'(n1);
            un_next[i][1] = n2[33] ? UN_W'(-n2) : UN_W'(n2);
            ud_next[i]    = cos_reg[i][31] ? UD_W'(-cos_reg[i]) : UD_W'(cos_reg[i]);
            side_next.skip[i]   = (cos_reg[i] == 32'sd0);
            side_next.neg[i][0] = n1[33] ^ cos_reg[i][31];
            side_next.neg[i][1] = n2[33] ^ cos_reg[i][31];
        end
    end

    always_ff @(posedge clk)
    begin
        un_reg    <= un_next;
        ud_reg    <= ud_next;
        side7_reg <= side_next;
    end

    // Dividers
    logic [2:0][1:0][Q_W-1:0] quot;
    logic [2:0][1:0]          ovf;
    logic                     div_vld;
    side_t                    side_d_reg [0:Q_W-1];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_axis
        for (genvar gk = 0; gk < 2; gk++)
        begin : g_bound
            if (gi == 0 && gk == 0)
            begin : g_lead
                robst_div u_div (
                    .clk(clk), .rst_n(rst_n), .in_valid(v7_reg),
                    .un(un_reg[gi][gk]), .ud(ud_reg[gi]),
                    .out_valid(div_vld), .quot(quot[gi][gk]), .ovf(ovf[gi][gk]));
            end
            else
            begin : g_rest
                robst_div u_div (
                    .clk(clk), .rst_n(rst_n), .in_valid(v7_reg),
                    .un(un_reg[gi][gk]), .ud(ud_reg[gi]),
                    .out_valid(), .quot(quot[gi][gk]), .ovf(ovf[gi][gk]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_d_reg[0] <= side7_reg;
        for (int s = 1; s < Q_W; s++)
            side_d_reg[s] <= side_d_reg[s-1];
    end

    // Saturate, order bounds, combine
    function automatic logic signed [31:0] sat(input logic [Q_W-1:0] q,
                                               input logic o, input logic n);
        if (n)
        begin
            if (o || q > Q_W'(33'h080000000))
                return 32'sh80000000;
            return 32'(-$signed({1'b0, q}));
        end
        if (o || q > Q_W'(33'h07FFFFFFF))
            return 32'sh7FFFFFFF;
        return 32'(q);
    endfunction

    logic signed [31:0] t_reg [0:2][0:1];
    logic signed [31:0] lo_reg [0:2];
    logic signed [31:0] hi_reg [0:2];
    logic [2:0]         skip_s_reg, skip_y_reg;
    logic signed [31:0] tmin_reg, tmax_reg;
    logic signed [31:0] tmin_next, tmax_next;
    logic               done_reg, hit_reg;
    logic signed [31:0] entry_reg;
    logic               vs_reg, vy_reg, vz_reg, v5_reg, v6_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 2; k++)
                t_reg[i][k] <= sat(quot[i][k], ovf[i][k], side_d_reg[Q_W-1].neg[i][k]);
            lo_reg[i] <= (t_reg[i][0] < t_reg[i][1]) ? t_reg[i][0] : t_reg[i][1];
            hi_reg[i] <= (t_reg[i][0] < t_reg[i][1]) ? t_reg[i][1] : t_reg[i][0];
        end
        skip_s_reg <= side_d_reg[Q_W-1].skip;
        skip_y_reg <= skip_s_reg;
        tmin_reg   <= tmin_next;
        tmax_reg   <= tmax_next;
        hit_reg    <= (tmax_reg >= tmin_reg) && (tmax_reg > 32'sd0);
        entry_reg  <= tmin_reg;
    end

    always_comb
    begin
        tmin_next = 32'sh80000000;
        tmax_next = 32'sh7FFFFFFF;
        for (int i = 0; i < 3; i++)
        begin
            if (!skip_y_reg[i])
            begin
                if (lo_reg[i] > tmin_next)
                    tmin_next = lo_reg[i];
                if (hi_reg[i] < tmax_next)
                    tmax_next = hi_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            vs_reg   <= 1'b0;
            vy_reg   <= 1'b0;
            vz_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v5_reg   <= ax_vld;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            vs_reg   <= div_vld;
            vy_reg   <= vs_reg;
            vz_reg   <= vy_reg;
            done_reg <= vz_reg;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign entry_time = entry_reg;

    `ROBST_ASSERT_DELAY(a_item_done, start && !busy, LATENCY, done)
    `ROBST_ASSERT_PAST(a_done_cause, done, start && !busy, LATENCY)
endmodule
